FILE: design/irdi_pkg.sv
// ----------------------------------------------------------------------------
// irdi_pkg
// Shared types, constants and tables for the IR ADC to distance interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package irdi_pkg;

    localparam int NUM_PTS = 6;                  // calibration points
    localparam int PT_W    = 12;                 // ADC sample / point width
    localparam int DIST_W  = 7;                  // distance in cm
    localparam int DIFF_W  = 6;                  // far_dist - near_dist, at most 40
    localparam int QUO_W   = 6;                  // quotient never exceeds 40
    localparam int SEG_W   = 3;                  // segment / register index
    localparam int REM_W   = DIFF_W + PT_W;      // product diff * num
    localparam int DSH_W   = PT_W + QUO_W - 1;   // divisor aligned to top quotient bit
    localparam int CLP_W   = PT_W + 6;           // 51 * 4095 fits 18 bits

    localparam logic [DIST_W-1:0] DIST_NEAR = DIST_W'(9);
    localparam logic [DIST_W-1:0] DIST_FAR  = DIST_W'(80);

    typedef logic [NUM_PTS-1:0][PT_W-1:0] pts_t;

    // One request moving down the divider chain
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] near_d;
        logic [REM_W-1:0]  rem;
        logic [DSH_W-1:0]  den_sh;
        logic [QUO_W-1:0]  quo;
    } irdi_cell_t;

    function automatic logic [DIST_W-1:0] dist_of(input logic [SEG_W-1:0] seg);
        logic [DIST_W-1:0] d;
        case (seg)
            3'd0:    d = DIST_W'(9);
            3'd1:    d = DIST_W'(15);
            3'd2:    d = DIST_W'(20);
            3'd3:    d = DIST_W'(30);
            3'd4:    d = DIST_W'(40);
            3'd5:    d = DIST_W'(80);
            default: d = DIST_W'(80);
        endcase
        return d;
    endfunction

    function automatic logic [PT_W-1:0] pt_reset(input int idx);
        logic [PT_W-1:0] p;
        case (idx)
            0:       p = PT_W'(3000);
            1:       p = PT_W'(2000);
            2:       p = PT_W'(1600);
            3:       p = PT_W'(1100);
            4:       p = PT_W'(850);
            default: p = PT_W'(450);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: design/irdi_front.sv
// ----------------------------------------------------------------------------
// irdi_front
// Clamp test, segment search and numerator/denominator setup (two stages).
// ----------------------------------------------------------------------------
`default_nettype none

module irdi_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [irdi_pkg::PT_W-1:0] sample,
    input  wire irdi_pkg::pts_t            pts,
    output irdi_pkg::irdi_cell_t           cell_out
);
    import irdi_pkg::*;

    // stage A
    logic              a_valid_reg, a_valid_next;
    logic [PT_W-1:0]   a_sample_reg;
    logic [SEG_W-1:0]  a_seg_reg, a_seg_next;
    logic              a_clamp_reg, a_clamp_next;
    logic [DIST_W-1:0] a_cdist_reg, a_cdist_next;

    // stage B
    irdi_cell_t        b_reg, b_next;

    logic [CLP_W-1:0]  s50, far49, far51;
    logic [PT_W-1:0]   near_pt, far_pt, den, num, gap;
    logic [DIFF_W-1:0] diff;
    logic [DIST_W-1:0] near_d;

    always_comb begin
        s50   = CLP_W'(sample) * CLP_W'(50);
        far51 = CLP_W'(pts[NUM_PTS-1]) * CLP_W'(51);
        far49 = CLP_W'(pts[0]) * CLP_W'(49);
        a_valid_next = in_valid;
        a_clamp_next = 1'b1;
        a_cdist_next = DIST_FAR;
        if (s50 <= far51) begin
            a_cdist_next = DIST_FAR;
        end else if (s50 >= far49) begin
            a_cdist_next = DIST_NEAR;
        end else begin
            a_clamp_next = 1'b0;
        end
        // last point above the sample
        a_seg_next = '0;
        for (int i = 0; i < NUM_PTS - 1; i++) begin
            if (pts[i] > sample) begin
                a_seg_next = SEG_W'(i);
            end
        end
    end

    always_comb begin
        near_pt = pts[a_seg_reg];
        far_pt  = pts[a_seg_reg + SEG_W'(1)];
        near_d  = dist_of(a_seg_reg);
        diff    = DIFF_W'(dist_of(a_seg_reg + SEG_W'(1)) - near_d);
        den     = near_pt - far_pt;
        gap     = (a_sample_reg < near_pt) ? (near_pt - a_sample_reg) : '0;
        num     = (gap > den) ? den : gap;

        b_next.valid  = a_valid_reg;
        b_next.quo    = '0;
        if (a_clamp_reg || (near_pt <= far_pt)) begin
            // force a zero quotient
            b_next.near_d = a_clamp_reg ? a_cdist_reg : near_d;
            b_next.rem    = '0;
            b_next.den_sh = DSH_W'(1) << (QUO_W - 1);
        end else begin
            b_next.near_d = near_d;
            b_next.rem    = REM_W'(diff) * REM_W'(num);
            b_next.den_sh = DSH_W'(den) << (QUO_W - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_reg.valid <= 1'b0;
        end else if (en) begin
            a_valid_reg <= a_valid_next;
            b_reg.valid <= b_next.valid;
        end
        if (en) begin
            a_sample_reg  <= sample;
            a_seg_reg     <= a_seg_next;
            a_clamp_reg   <= a_clamp_next;
            a_cdist_reg   <= a_cdist_next;
            b_reg.near_d  <= b_next.near_d;
            b_reg.rem     <= b_next.rem;
            b_reg.den_sh  <= b_next.den_sh;
            b_reg.quo     <= b_next.quo;
        end
    end

    assign cell_out = b_reg;

endmodule

`default_nettype wire

FILE: design/irdi_div_cell.sv
// ----------------------------------------------------------------------------
// irdi_div_cell
// One restoring-division step: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module irdi_div_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire irdi_pkg::irdi_cell_t  cell_in,
    output irdi_pkg::irdi_cell_t       cell_out
);
    import irdi_pkg::*;

    irdi_cell_t cell_reg, cell_next;
    logic       ge;

    always_comb begin
        ge = cell_in.rem >= REM_W'(cell_in.den_sh);
        cell_next.valid  = cell_in.valid;
        cell_next.near_d = cell_in.near_d;
        cell_next.rem    = ge ? (cell_in.rem - REM_W'(cell_in.den_sh)) : cell_in.rem;
        // hand the divisor down one bit position
        cell_next.den_sh = cell_in.den_sh >> 1;
        cell_next.quo    = {cell_in.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
        if (en) begin
            cell_reg.near_d <= cell_next.near_d;
            cell_reg.rem    <= cell_next.rem;
            cell_reg.den_sh <= cell_next.den_sh;
            cell_reg.quo    <= cell_next.quo;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

FILE: design/ir_adc_to_distance_interp.sv
// ----------------------------------------------------------------------------
// ir_adc_to_distance_interp
// IR range sensor ADC sample to distance in cm by piecewise linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one 12-bit ADC sample per request; m_tdata returns one
//   7-bit distance (9..80 cm) per sample, in order.
//   Six calibration points are written through cfg_wen/cfg_index/cfg_wdata
//   (index 0 = 9 cm point ... 5 = 80 cm point); other indexes are ignored.
//   Write them only while no sample is in flight.
//   The result passes through two setup stages, six division cells (one
//   quotient bit each), and the output register.
//   Throughput: one sample per cycle unless stalled; the chain advances together.
//   When m_tready is low with a result held, the chain freezes and s_tready
//   drops; it rises again in the cycle the held result is taken.
//   Reset (aresetn low, synchronous) empties the chain and restores the
//   calibration points to 3000, 2000, 1600, 1100, 850 and 450.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_adc_to_distance_interp (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] adc_sample, [15:12] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] distance_cm, [7] zero
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata
);
    import irdi_pkg::*;

    pts_t              pts_reg;
    logic              en;
    irdi_cell_t        chain [QUO_W+1];
    logic              m_valid_reg, m_valid_next;
    logic [DIST_W-1:0] m_dist_reg, m_dist_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PTS; i++) begin
                pts_reg[i] <= pt_reset(i);
            end
        end else if (cfg_wen && (cfg_index < SEG_W'(NUM_PTS))) begin
            pts_reg[cfg_index] <= cfg_wdata;
        end
    end

    // advance whenever the output slot is free or being emptied
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    irdi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .sample   (s_tdata[PT_W-1:0]),
        .pts      (pts_reg),
        .cell_out (chain[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        irdi_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    always_comb begin
        m_valid_next = chain[QUO_W].valid;
        m_dist_next  = chain[QUO_W].near_d + DIST_W'(chain[QUO_W].quo);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_dist_reg <= m_dist_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_dist_reg};

endmodule

`default_nettype wire

FILE: tb/sv/tb_ir_adc_to_distance_interp.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_adc_to_distance_interp
// Self-checking bench for the IR ADC sample to distance interpolator. Samples
// stream in under bursty valid and a stalling receiver; every accepted sample
// is converted to a predicted distance with the current calibration points
// and compared in order with the returned distances. Several calibration sets
// are used in turn across phases: reset values, extremes, tight and unordered
// points, and random descending sets.
// ----------------------------------------------------------------------------

module tb_ir_adc_to_distance_interp;

    import irdi_pkg::*;

    localparam int QUIET_LIMIT  = 2000;   // cycles with no request moved
    localparam int DRAIN_CYCLES = 24;     // chain latency plus margin

    typedef enum logic [2:0] {
        REG_PT_9CM, REG_PT_15CM, REG_PT_20CM, REG_PT_30CM, REG_PT_40CM, REG_PT_80CM,
        REG_SPARE_6, REG_SPARE_7
    } cal_reg_e;

    typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PERIODIC} sink_mode_e;

    typedef struct {
        logic [PT_W-1:0]   sample;
        logic [DIST_W-1:0] distance;
    } distance_exp_t;

    // ------------------------------------------------------------------------
    // Distance predictor and in-order result store
    // ------------------------------------------------------------------------
    class distance_scoreboard;
        logic [PT_W-1:0] cal_pt[NUM_PTS];
        int unsigned     seg_dist[NUM_PTS];
        distance_exp_t   expected_q[$];
        int unsigned     mismatches;

        function new();
            seg_dist = '{9, 15, 20, 30, 40, 80};
            cal_pt   = '{12'd3000, 12'd2000, 12'd1600, 12'd1100, 12'd850, 12'd450};
            mismatches = 0;
        endfunction

        function void write_point(cal_reg_e idx, logic [PT_W-1:0] val);
            // spare indexes are dropped by the block
            if (idx <= REG_PT_80CM)
                cal_pt[idx] = val;
        endfunction

        function logic [DIST_W-1:0] predict_distance(logic [PT_W-1:0] smp);
            int unsigned x, seg, near_pt, far_pt, span, drop, i;
            x = smp;
            if (50 * x <= 51 * cal_pt[NUM_PTS-1])
                return DIST_W'(seg_dist[NUM_PTS-1]);
            if (50 * x >= 49 * cal_pt[0])
                return DIST_W'(seg_dist[0]);
            seg = 0;
            for (i = 0; i < NUM_PTS - 1; i++)
                if (cal_pt[i] > x)
                    seg = i;
            near_pt = cal_pt[seg];
            far_pt  = cal_pt[seg+1];
            if (near_pt <= far_pt)
                return DIST_W'(seg_dist[seg]);
            span = near_pt - far_pt;
            drop = (x < near_pt) ? near_pt - x : 0;
            if (drop > span)
                drop = span;
            return DIST_W'(seg_dist[seg] + (seg_dist[seg+1] - seg_dist[seg]) * drop / span);
        endfunction

        function void note_sample(logic [PT_W-1:0] smp);
            distance_exp_t e;
            e.sample   = smp;
            e.distance = predict_distance(smp);
            expected_q.push_back(e);
        endfunction

        function void check_distance(logic [7:0] tdata);
            distance_exp_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected distance %0d with no sample pending", tdata[DIST_W-1:0]);
                return;
            end
            e = expected_q.pop_front();
            if (tdata[DIST_W-1:0] !== e.distance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance mismatch: sample %0d expected %0d got %0d",
                             e.sample, e.distance, tdata[DIST_W-1:0]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and stimulus signals
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;     // [11:0] adc_sample, [15:12] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;            // [6:0] distance_cm, [7] zero
    logic        cfg_wen   = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_wdata = '0;

    distance_scoreboard sb = new();
    sink_mode_e         sink_mode    = SINK_ALWAYS;
    bit                 hold_request = 1'b0;

    ir_adc_to_distance_interp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [PT_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp);
    endtask

    // Load all six points back to back, optionally followed by writes to the
    // spare indexes that must not disturb them.
    task automatic load_points(input logic [PT_W-1:0] pts[NUM_PTS], input bit poke_spare);
        int j;
        for (j = 0; j < NUM_PTS; j++) begin
            cfg_wen   <= 1'b1;
            cfg_index <= cal_reg_e'(j);
            cfg_wdata <= pts[j];
            @(posedge aclk);
            sb.write_point(cal_reg_e'(j), pts[j]);
        end
        if (poke_spare) begin
            cfg_index <= REG_SPARE_6;
            cfg_wdata <= 12'($urandom);
            @(posedge aclk);
            cfg_index <= REG_SPARE_7;
            cfg_wdata <= 12'($urandom);
            @(posedge aclk);
        end
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [PT_W-1:0] clip_sample(input int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'hFFF;
        return PT_W'(v);
    endfunction

    // Mostly samples inside the calibrated span, with extra weight on the
    // points themselves and on both clamp thresholds.
    function automatic logic [PT_W-1:0] pick_sample();
        int sel, k, lo, hi, j;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, NUM_PTS - 1);
        if (sel < 15)
            return 12'($urandom);
        if (sel < 35)
            return clip_sample(int'(sb.cal_pt[k]) + $urandom_range(0, 6) - 3);
        if (sel < 42)
            return clip_sample(51 * int'(sb.cal_pt[NUM_PTS-1]) / 50 + $urandom_range(0, 4) - 2);
        if (sel < 49)
            return clip_sample((49 * int'(sb.cal_pt[0]) + 49) / 50 + $urandom_range(0, 4) - 2);
        lo = 4095;
        hi = 0;
        for (j = 0; j < NUM_PTS; j++) begin
            if (sb.cal_pt[j] < lo) lo = sb.cal_pt[j];
            if (sb.cal_pt[j] > hi) hi = sb.cal_pt[j];
        end
        return PT_W'($urandom_range(hi, lo));
    endfunction

    task automatic send_phase(input int n, input bit bursty, input bit pressure);
        int i, burst_left, gap;
        burst_left = 0;
        for (i = 0; i < n; i++) begin
            if (pressure && i == n / 3)
                hold_request = 1'b1;
            if (bursty) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = $urandom_range(0, 6);
                    if (gap > 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
                burst_left--;
            end
            send_sample(pick_sample());
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result sink: own stall pattern plus an occasional long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        int unsigned beat;
        hold_left = 0;
        beat = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_distance(m_tdata);
            if (hold_request) begin
                hold_left = $urandom_range(40, 80);
                hold_request = 1'b0;
            end
            beat++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_ALWAYS:   m_tready <= 1'b1;
                    SINK_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 30);
                    SINK_PERIODIC: m_tready <= ((beat % 7) < 4);
                    default:       m_tready <= 1'b1;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [PT_W-1:0] pts[NUM_PTS];
        logic [PT_W-1:0] draw_q[$];
        logic [PT_W-1:0] directed_q[$];
        int r, j;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset points: clamps on both sides, threshold neighbors, each point (with
        // neighbors around 2000 and 850), points inside segments, and alternating bit patterns.
        directed_q = '{12'd0, 12'd4095, 12'd459, 12'd460, 12'd2939, 12'd2940,
                       12'd3000, 12'd2001, 12'd2000, 12'd1999, 12'd1600, 12'd1100,
                       12'd851, 12'd850, 12'd849, 12'd450, 12'd1800, 12'd975,
                       12'd650, 12'd1350, 12'd2500, 12'hAAA, 12'h555};
        foreach (directed_q[j])
            send_sample(directed_q[j]);
        s_tvalid <= 1'b0;
        wait_drained();

        sink_mode = SINK_RANDOM;
        send_phase(527, 1'b1, 1'b1);
        wait_drained();

        // Widest span: top and bottom of the converter range
        pts = '{12'd4095, 12'd4000, 12'd3000, 12'd2000, 12'd1000, 12'd0};
        load_points(pts, 1'b1);
        sink_mode = SINK_PERIODIC;
        send_phase(250, 1'b1, 1'b0);
        wait_drained();

        // Tight points at the top of the range
        pts = '{12'd4095, 12'd4094, 12'd4093, 12'd4092, 12'd4091, 12'd4090};
        load_points(pts, 1'b0);
        sink_mode = SINK_ALWAYS;
        send_phase(150, 1'b0, 1'b0);
        wait_drained();

        // Tight points near zero
        pts = '{12'd10, 12'd9, 12'd8, 12'd7, 12'd6, 12'd5};
        load_points(pts, 1'b1);
        sink_mode = SINK_RANDOM;
        send_phase(150, 1'b1, 1'b1);
        wait_drained();

        // Points out of order or equal: segment collapses to its near distance
        for (r = 0; r < 2; r++) begin
            for (j = 0; j < NUM_PTS; j++)
                pts[j] = (r == 0) ? 12'd2000 : 12'($urandom);
            if (r == 0)
                pts[NUM_PTS-1] = 12'd400;
            load_points(pts, 1'b1);
            sink_mode = (r == 0) ? SINK_PERIODIC : SINK_RANDOM;
            send_phase(125, 1'b1, 1'b0);
            wait_drained();
        end

        // Random descending calibration sets
        for (r = 0; r < 4; r++) begin
            draw_q.delete();
            for (j = 0; j < NUM_PTS; j++)
                draw_q.push_back(12'($urandom));
            draw_q.rsort();
            for (j = 0; j < NUM_PTS; j++)
                pts[j] = draw_q[j];
            load_points(pts, r[0]);
            sink_mode = sink_mode_e'(r % 3);
            send_phase(100, r != 2, r == 1);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/irdi_pkg.sv
design/irdi_front.sv
design/irdi_div_cell.sv
design/ir_adc_to_distance_interp.sv
tb/sv/tb_ir_adc_to_distance_interp.sv
